[src/vftc_pkg.sv]
// Shared widths, constants and register codes for the video frame timing counter.
// No dependencies; used by vftc_scaler and video_frame_timing_counter_core.
package vftc_pkg;

  // Field widths
  localparam int CYCLES_W  = 16;
  localparam int REM_W     = 3;
  localparam int SCALED_W  = 20;
  localparam int CLOCKS_W  = 17;
  localparam int POS_W     = 20;

  // Default line length in video clocks
  localparam int LINE_CLOCKS_DEFAULT = 3413;

  // CPU-to-video clock ratio 11/7
  localparam int unsigned RATIO_MUL = 11;
  localparam int unsigned RATIO_DIV = 7;

  // Reciprocal of 7: floor(x * DIV7_MULT / 2^DIV7_SHIFT) == x / 7 for x < 2^20
  localparam int DIV7_SHIFT  = 23;
  localparam int DIV7_MULT_W = 21;
  localparam logic [DIV7_MULT_W-1:0] DIV7_MULT = 21'd1198373;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [0:0] {
    REG_INTERLACE_480 = 1'b0
  } reg_index_t;

endpackage

[src/video_frame_timing_counter_core.sv]
// Video frame timing counter: CPU-to-video scaling by RATIO_MUL/RATIO_DIV, frame position, vblank and field flags.
// An accepted transaction's clocks are registered in the scaler, then its flags at the output when stage 2 loads.
// Throughput: one transaction per cycle unless a held result stalls on out_ready; the remainder loop closes through the
// reciprocal multiply in the scaler, the position loop through one add and wrap subtract.
// Synchronous active-high reset clears remainder, position, field, mode and pipeline valids.
// Depends on vftc_pkg and vftc_scaler.
module video_frame_timing_counter_core #(
  parameter int LINE_CLOCKS = vftc_pkg::LINE_CLOCKS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vftc_pkg::CYCLES_W-1:0] cpu_cycles,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          blank_begin,
  output logic                          blank_end,
  output logic                          frame_done,
  output logic                          current_field,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vftc_pkg::ADDR_W-1:0]   paddr,
  input  logic [vftc_pkg::DATA_W-1:0]   pwdata,
  output logic [vftc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int SUM_W = vftc_pkg::POS_W + 1;
  localparam logic [SUM_W-1:0] FRAME_END    = SUM_W'((525 * LINE_CLOCKS + 1) / 2);
  localparam logic [SUM_W-1:0] VBLANK_BEGIN = SUM_W'(241 * LINE_CLOCKS);

  logic                          interlace_480;
  logic                          s1_valid;
  logic                          s1_load;
  logic                          s2_load;
  logic [vftc_pkg::CLOCKS_W-1:0] clocks;
  logic [vftc_pkg::POS_W-1:0]    frame_position;
  logic [vftc_pkg::POS_W-1:0]    frame_position_next;
  logic                          field_bit;
  logic                          field_bit_next;
  logic [SUM_W-1:0]              pos_sum;
  logic                          wrapped;
  logic                          vs_hit;
  logic                          reg_sel;

  // Configuration register access
  assign pready  = 1'b1;
  assign reg_sel = (vftc_pkg::reg_index_t'(paddr[2]) == vftc_pkg::REG_INTERLACE_480);

  always_ff @(posedge clk) begin
    if (rst) begin
      interlace_480 <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      interlace_480 <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {{(vftc_pkg::DATA_W-1){1'b0}}, interlace_480} : '0;

  // Pipeline flow: stage 2 moves when the result slot is free or drained
  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = s2_load || !s1_valid;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage 1: scale cycles to video clocks
  vftc_scaler u_scaler (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_load),
    .cpu_cycles (cpu_cycles),
    .clocks     (clocks)
  );

  // Stage 2: advance position, wrap at frame end, detect vblank start
  assign pos_sum = SUM_W'(frame_position) + SUM_W'(clocks);
  assign wrapped = (pos_sum >= FRAME_END);
  assign vs_hit  = (SUM_W'(frame_position) < VBLANK_BEGIN) && (pos_sum >= VBLANK_BEGIN);
  assign frame_position_next = wrapped ? vftc_pkg::POS_W'(pos_sum - FRAME_END)
                                       : vftc_pkg::POS_W'(pos_sum);

  // Toggle the field in interlaced mode, force odd otherwise
  always_comb begin
    field_bit_next = field_bit;
    if (wrapped) begin
      field_bit_next = interlace_480 ? ~field_bit : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      field_bit      <= 1'b0;
    end else if (s2_load) begin
      frame_position <= frame_position_next;
      field_bit      <= field_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      blank_begin <= vs_hit;
      blank_end   <= wrapped;
      frame_done  <= wrapped;
    end
  end

  // Field register only changes when a new result is loaded
  assign current_field = field_bit;

endmodule

[src/vftc_scaler.sv]
// CPU cycle to video clock scaler (ratio 11/7) with its remainder register.
// Depends on vftc_pkg.
module vftc_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [vftc_pkg::CYCLES_W-1:0] cpu_cycles,
  output logic [vftc_pkg::CLOCKS_W-1:0] clocks
);

  localparam int PROD_W = vftc_pkg::SCALED_W + vftc_pkg::DIV7_MULT_W;

  logic [vftc_pkg::REM_W-1:0]    clock_remainder;
  logic [vftc_pkg::REM_W-1:0]    clock_remainder_next;
  logic [vftc_pkg::SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]             product;
  logic [vftc_pkg::CLOCKS_W-1:0] quotient;
  logic [vftc_pkg::SCALED_W-1:0] quotient_x7;

  // Scale cycles by 11 and add the pending sevenths
  assign scaled = vftc_pkg::SCALED_W'(cpu_cycles) * vftc_pkg::SCALED_W'(vftc_pkg::RATIO_MUL)
                + vftc_pkg::SCALED_W'(clock_remainder);

  // Divide by 7 through the reciprocal
  assign product  = PROD_W'(scaled) * PROD_W'(vftc_pkg::DIV7_MULT);
  assign quotient = product[vftc_pkg::DIV7_SHIFT +: vftc_pkg::CLOCKS_W];

  // Remainder is what the quotient leaves over
  assign quotient_x7 = (vftc_pkg::SCALED_W'(quotient) << 3) - vftc_pkg::SCALED_W'(quotient);
  assign clock_remainder_next = vftc_pkg::REM_W'(scaled - quotient_x7);

  // Hold remainder and the whole clocks of the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_remainder <= '0;
    end else if (load) begin
      clock_remainder <= clock_remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      clocks <= quotient;
    end
  end

endmodule
